// File: hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the item and result beat structs, the kind codes and the sequencer states.
// No dependencies.
`default_nettype none

package tcw_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] ATTR_RESET   = 8'h02;

  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_ATTR_ADDR = 2'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
  } tcw_result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } tcw_state_e;

endpackage

`default_nettype wire

// File: hdl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/tcw_regs.sv
// APB-style configuration register file: the text attribute byte.
// Depends on tcw_pkg.
`default_nettype none

module tcw_regs
  import tcw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  output      logic [7:0]         attr_o
);

  logic [7:0] attr_q, attr_d;

  always_comb begin
    attr_d = attr_q;
    if (psel && penable && pwrite && pready && (paddr == REG_ATTR_ADDR)) begin
      attr_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ATTR_ADDR) ? {24'd0, attr_q} : 32'd0;
  assign attr_o = attr_q;

endmodule

`default_nettype wire

// File: hdl/tcw_ctrl.sv
// Sequencer and cursor of the console: owns the screen RAM and walks it for
// clear, scroll and the clearing pass after reset. Depends on tcw_pkg, tcw_ram.
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS    = 25,
  parameter int unsigned COLUMNS = 80
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire tcw_item_t   item_i,
  input  wire logic [7:0]  attr_i,
  output      logic        busy_o,
  output      logic        done_o,
  output      tcw_result_t result_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned PW    = $clog2(CELLS + 1);

  tcw_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic [15:0]   wr_data_q, wr_data_d;
  logic          rd_ok_q, rd_ok_d;
  logic          done_q, done_d;
  tcw_result_t   result_q, result_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic          is_nl, wrap, adv, last_row, scroll;
  logic [CW-1:0] col_w;
  logic [PW-1:0] pos_d;
  logic [15:0]   cell_d;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    is_nl    = (item_i.char_code == NEWLINE_CODE);
    wrap     = !is_nl && (col_q == CW'(COLUMNS));
    adv      = is_nl || wrap;
    last_row = (row_q == RW'(ROWS - 1));
    scroll   = adv && last_row;
    col_w    = adv ? '0 : col_q;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    row_d     = row_q;
    col_d     = col_q;
    base_d    = base_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    wr_data_d = wr_data_q;
    rd_ok_d   = rd_ok_q;
    done_d    = 1'b0;
    cell_d    = '0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = '0;
    mem_raddr = cnt_q + AW'(COLUMNS);

    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        mem_raddr = AW'(item_i.cell_index);
        if (start_i) begin
          unique case (item_i.kind)
            KIND_PUT: begin
              if (adv && !last_row) begin
                row_d  = row_q + RW'(1);
                base_d = base_q + AW'(COLUMNS);
              end
              col_d     = is_nl ? '0 : col_w + CW'(1);
              wr_pend_d = !is_nl;
              wr_addr_d = base_d + AW'(col_w);
              wr_data_d = {attr_i, item_i.char_code};
              if (scroll) begin
                cnt_d   = '0;
                state_d = ST_COPY;
              end else if (!is_nl) begin
                state_d = ST_WRITE;
              end else begin
                done_d = 1'b1;
              end
            end
            KIND_READ: begin
              rd_ok_d = (32'(item_i.cell_index) < 32'(CELLS));
              state_d = ST_READ;
            end
            KIND_CLEAR: begin
              cnt_d     = '0;
              wr_pend_d = 1'b0;
              state_d   = ST_FILL;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr_q;
        mem_wdata = wr_data_q;
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        cell_d  = rd_ok_q ? mem_rdata : '0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_q - AW'(1);
        mem_wdata = mem_rdata;
        if (cnt_q == AW'(CELLS - COLUMNS)) begin
          state_d = ST_FILL;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d = '0;
          if (wr_pend_q) begin
            state_d = ST_WRITE;
          end else begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    pos_d                     = PW'(base_d) + PW'(col_d);
    result_d.cursor_position  = 11'(pos_d);
    result_d.cell_value       = cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      base_q    <= '0;
      wr_pend_q <= 1'b0;
      rd_ok_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      col_q     <= col_d;
      base_q    <= base_d;
      wr_pend_q <= wr_pend_d;
      rd_ok_q   <= rd_ok_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    wr_data_q <= wr_data_d;
    if (done_d) begin
      result_q <= result_d;
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// File: hdl/text_console_writer.sv
// Top level of the text console writer: configuration registers and sequencer.
// Depends on tcw_pkg, tcw_regs, tcw_ctrl.
//
// Usage:
//   Command channel: an item beat (kind, char_code, cell_index) is taken at a
//   rising edge with start high and busy low. Kinds: put character, read one
//   cell, clear screen.
//   Result channel: done_o pulses for one cycle with result_o holding the
//   cursor position after the item and, for reads, the cell contents. The
//   receiver cannot stall; one result beat per item.
//   Steps from the accept edge to the done_o pulse:
//     newline without scroll, unused kind: done_o set straight from idle
//     plain character, read: one RAM write or read state
//     clear: every cell zeroed in turn (one cell zeroed per cycle)
//     a put that scrolls adds a row copy through the RAM read and write
//     ports, then the bottom row zeroed
//   Plain characters: busy stays high during the RAM write, so the next item waits.
//   Reset: cursor goes home, attribute returns to 0x02, and busy stays high
//   while the screen RAM is zeroed.
//   Configuration: APB port, text attribute at address 0; write only when idle.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS    = 25,
  parameter int unsigned COLUMNS = 80
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire tcw_item_t          item_i,
  output      logic               done_o,
  output      tcw_result_t        result_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  logic [7:0] attr;

  tcw_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .attr_o (attr)
  );

  tcw_ctrl #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .attr_i  (attr),
    .busy_o  (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_text_console_writer.sv
// Self-checking testbench for text_console_writer: a scoreboard class mirrors the
// screen, cursor and attribute, and checks every result beat against its prediction.
// Depends on tcw_pkg and text_console_writer.
`default_nettype none

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int unsigned ROWS           = 25;
  localparam int unsigned COLUMNS        = 80;
  localparam int unsigned CELL_COUNT     = ROWS * COLUMNS;
  localparam int          CLK_HALF       = 5;
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;
  localparam int unsigned PHASE_COUNT    = 5;
  localparam int unsigned PHASE_ITEMS    = 360;
  localparam int unsigned WATCHDOG_LIMIT = 25000;
  localparam int unsigned TAIL_CYCLES    = 20;

  class console_scoreboard;
    logic [15:0]  screen_mirror [CELL_COUNT];
    int unsigned  row;
    int unsigned  col;
    logic [7:0]   attribute;
    tcw_result_t  pending_results [$];
    int unsigned  error_count;

    function new();
      blank_screen();
      row         = 0;
      col         = 0;
      attribute   = ATTR_RESET;
      error_count = 0;
    endfunction

    function void blank_screen();
      int i;
      for (i = 0; i < CELL_COUNT; i++) screen_mirror[i] = '0;
    endfunction

    function void set_attribute(logic [7:0] value);
      attribute = value;
    endfunction

    function void next_row();
      int i;
      row++;
      col = 0;
      if (row >= ROWS) begin
        for (i = 0; i < CELL_COUNT - COLUMNS; i++) screen_mirror[i] = screen_mirror[i + COLUMNS];
        for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_mirror[i] = '0;
        row = ROWS - 1;
      end
    endfunction

    function void note_item(tcw_item_t it);
      tcw_result_t want;
      want.cell_value = '0;
      case (it.kind)
        KIND_PUT: begin
          if (it.char_code == NEWLINE_CODE) begin
            next_row();
          end else begin
            if (col >= COLUMNS) next_row();
            screen_mirror[row * COLUMNS + col] = {attribute, it.char_code};
            col++;
          end
        end
        KIND_READ: begin
          if (it.cell_index < CELL_COUNT) want.cell_value = screen_mirror[it.cell_index];
        end
        KIND_CLEAR: begin
          blank_screen();
        end
        default: begin
        end
      endcase
      want.cursor_position = 11'(row * COLUMNS + col);
      pending_results.push_back(want);
    endfunction

    function void check_result(tcw_result_t got);
      tcw_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: cursor_position %0d cell_value %h",
               got.cursor_position, got.cell_value);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.cursor_position !== want.cursor_position) begin
        $error("cursor_position: expected %0d, actual %0d",
               want.cursor_position, got.cursor_position);
        error_count++;
      end
      if (got.cell_value !== want.cell_value) begin
        $error("cell_value: expected %h, actual %h", want.cell_value, got.cell_value);
        error_count++;
      end
    endfunction
  endclass

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               start    = 1'b0;
  logic               busy;
  tcw_item_t          cmd_item = '0;
  logic               done_o;
  tcw_result_t        result_beat;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  console_scoreboard sb = new();
  int unsigned       items_sent = 0;
  int unsigned       gap_pct    = 28;
  int unsigned       stall_cycles = 0;

  text_console_writer #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (cmd_item),
    .done_o   (done_o),
    .result_o (result_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(result_beat);
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_text_console_writer: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic tcw_item_t compose(logic [1:0] kind, logic [7:0] code, logic [10:0] idx);
    tcw_item_t it;
    it.kind       = kind;
    it.char_code  = code;
    it.cell_index = idx;
    return it;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] code;
    code = 8'($urandom_range(0, 255));
    if (code == NEWLINE_CODE) code = 8'h20;
    return code;
  endfunction

  function automatic logic [10:0] read_index();
    if ($urandom_range(0, 9) == 0) return 11'($urandom_range(CELL_COUNT, 2047));
    return 11'($urandom_range(0, CELL_COUNT - 1));
  endfunction

  task automatic issue_item(input tcw_item_t it);
    start    <= 1'b1;
    cmd_item <= it;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sb.note_item(it);
    items_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_results.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= REG_ATTR_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (write) begin
      sb.set_attribute(value);
    end else if (prdata[7:0] !== value) begin
      $error("text_attribute: expected %h, actual %h", value, prdata[7:0]);
      sb.error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_line();
    int unsigned len;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) len = $urandom_range(0, 30);
    else if (r < 9) len = $urandom_range(70, 90);
    else len = $urandom_range(100, 170);
    repeat (len) issue_item(compose(KIND_PUT, text_byte(), 11'($urandom_range(0, 2047))));
    if ($urandom_range(0, 9) < 8) issue_item(compose(KIND_PUT, NEWLINE_CODE, '0));
  endtask

  task automatic run_phase();
    int unsigned phase_start;
    int unsigned pick;
    phase_start = items_sent;
    while (items_sent - phase_start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_line();
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 6))
          issue_item(compose(KIND_READ, 8'($urandom_range(0, 255)), read_index()));
      end else if (pick < 96) begin
        issue_item(compose(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           11'($urandom_range(0, 2047))));
      end else begin
        issue_item(compose(KIND_CLEAR, 8'($urandom_range(0, 255)),
                           11'($urandom_range(0, 2047))));
      end
    end
  endtask

  initial begin
    logic [7:0] attr_value;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    apb_access(1'b0, ATTR_RESET);

    issue_item(compose(KIND_PUT, 8'h41, '0));
    issue_item(compose(KIND_PUT, 8'h00, '0));
    issue_item(compose(KIND_PUT, 8'hFF, 11'd2047));
    issue_item(compose(KIND_PUT, NEWLINE_CODE, '0));
    issue_item(compose(KIND_PUT, 8'h7E, '0));
    issue_item(compose(KIND_READ, '0, 11'd0));
    issue_item(compose(KIND_READ, '0, 11'd1));
    issue_item(compose(KIND_READ, '0, 11'd2));
    issue_item(compose(KIND_READ, '0, 11'd80));
    issue_item(compose(KIND_READ, '0, 11'(CELL_COUNT - 1)));
    issue_item(compose(KIND_READ, '0, 11'(CELL_COUNT)));
    issue_item(compose(KIND_READ, 8'hFF, 11'd2047));
    issue_item(compose(KIND_UNUSED, 8'hFF, 11'd2047));
    issue_item(compose(KIND_UNUSED, NEWLINE_CODE, '0));
    issue_item(compose(KIND_PUT, NEWLINE_CODE, 11'd2047));
    issue_item(compose(KIND_READ, 8'hFF, 11'd0));
    issue_item(compose(KIND_CLEAR, 8'hFF, 11'd2047));
    issue_item(compose(KIND_READ, '0, 11'd0));
    issue_item(compose(KIND_READ, '0, 11'd80));
    issue_item(compose(KIND_PUT, 8'h55, '0));
    issue_item(compose(KIND_READ, '0, 11'(2 * COLUMNS)));

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      case (phase)
        0: attr_value = 8'hFF;
        1: attr_value = 8'h00;
        default: attr_value = 8'($urandom_range(0, 255));
      endcase
      apb_access(1'b1, attr_value);
      apb_access(1'b0, attr_value);
      gap_pct = (phase == 2) ? 0 : 28;
      run_phase();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected result beats never arrived", sb.pending_results.size());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("tb_text_console_writer: done, clean");
    end else begin
      $display("tb_text_console_writer: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_regs.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer.sv
tb/tb_text_console_writer.sv
